[sv/wsfd_pkg.sv]
package wsfd_pkg;

	localparam int LENGTH_BITS_DEF = 64;

	localparam logic [3:0] OP_CLOSE   = 4'h8;
	localparam logic [6:0] LEN_EXT16  = 7'd126;
	localparam logic [6:0] LEN_EXT64  = 7'd127;
	localparam logic [2:0] HDR_EXT16  = 3'd1;
	localparam logic [2:0] HDR_EXT64  = 3'd7;
	localparam logic [2:0] HDR_KEY    = 3'd3;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CLOSED  = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_CLOSE   = 2'd2
	} kind_t;

	typedef struct packed {
		logic       vld;
		kind_t      kind;
		logic [7:0] pbyte;
		logic [3:0] opcode;
		logic       last;
	} res_t;

endpackage

[sv/websocket_frame_deframer_core.sv]
// WebSocket receive-side deframer.
// Input channel: one stream byte per item on data_byte, in_valid/in_stall.
// Output channel: one item per payload byte (kind 0, unmasked), one
// empty-frame item (kind 1) for a zero-length frame, or one close item
// (kind 2) on the second header byte of an opcode 8 frame. Otherwise header, length
// and mask-key bytes produce no item. frame_opcode carries the frame's
// opcode nibble; last_of_frame marks the final item of a frame.
// Throughput: one byte per cycle while out_stall is low. An accepted byte
// passes through the input register, then parse logic into the result
// register, before its item shows on the outputs.
// Reset (arst_n low) empties both registers and returns the parser to the
// first header byte. After a close item all input is accepted and dropped
// until reset.
// When out_stall holds a waiting item, the input register still takes one
// more byte; in_stall rises once that byte cannot be retired.
// LENGTH_BITS sets the payload length counter width; longer extended
// lengths are truncated to it.
module websocket_frame_deframer_core #(
	parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [3:0] frame_opcode,
	output logic       last_of_frame
);
	import wsfd_pkg::*;

	logic       vld_s1;
	logic [7:0] data_s1;
	logic       out_ready;
	logic       consume;
	res_t       res;

	assign consume = vld_s1 && out_ready;

	wsfd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.consume   (consume),
		.vld_s1    (vld_s1),
		.data_s1   (data_s1)
	);

	wsfd_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.data_s1 (data_s1),
		.consume (consume),
		.res     (res)
	);

	wsfd_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.consume       (consume),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.frame_opcode  (frame_opcode),
		.last_of_frame (last_of_frame)
	);

endmodule

[sv/wsfd_in_stage.sv]
module wsfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       consume,
	output logic       vld_s1,
	output logic [7:0] data_s1
);

	// holds while the parser cannot retire the byte it has
	assign in_stall = vld_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
		end
	end

endmodule

[sv/wsfd_parser.sv]
module wsfd_parser #(
	parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_s1,
	input  logic [7:0]      data_s1,
	input  logic            consume,
	output wsfd_pkg::res_t  res
);
	import wsfd_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [3:0]             op_q, op_d;
	logic                   mask_q, mask_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic [2:0]             hdr_q, hdr_d;
	logic [31:0]            key_q, key_d;
	logic [1:0]             mpos_q, mpos_d;

	logic                   len_done, begin_pl, mask_sel;
	logic [LENGTH_BITS-1:0] len_val, rem_dec;
	logic [31:0]            key_sh;
	logic [7:0]             key_byte;

	assign key_sh   = key_q >> {~mpos_q, 3'b000};
	assign key_byte = mask_q ? key_sh[7:0] : 8'h00;
	assign rem_dec  = rem_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	always_comb begin
		phase_d  = phase_q;
		op_d     = op_q;
		mask_d   = mask_q;
		rem_d    = rem_q;
		hdr_d    = hdr_q;
		key_d    = key_q;
		mpos_d   = mpos_q;
		len_done = 1'b0;
		begin_pl = 1'b0;
		mask_sel = mask_q;
		len_val  = rem_q;
		res      = '{vld: 1'b0, kind: KIND_PAYLOAD, pbyte: 8'h00, opcode: op_q, last: 1'b1};

		unique case (phase_q)
			PH_HDR0: begin
				op_d    = data_s1[3:0];
				phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				mask_d   = data_s1[7];
				mask_sel = data_s1[7];
				if (op_q == OP_CLOSE) begin
					phase_d  = PH_CLOSED;
					res.vld  = 1'b1;
					res.kind = KIND_CLOSE;
				end else if (data_s1[6:0] == LEN_EXT16) begin
					rem_d   = '0;
					hdr_d   = HDR_EXT16;
					phase_d = PH_EXTLEN;
				end else if (data_s1[6:0] == LEN_EXT64) begin
					rem_d   = '0;
					hdr_d   = HDR_EXT64;
					phase_d = PH_EXTLEN;
				end else begin
					len_val  = {{(LENGTH_BITS-7){1'b0}}, data_s1[6:0]};
					rem_d    = len_val;
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				rem_d = {rem_q[LENGTH_BITS-9:0], data_s1};
				if (hdr_q == 3'd0) begin
					len_val  = rem_d;
					len_done = 1'b1;
				end else begin
					hdr_d = hdr_q - 3'd1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], data_s1};
				if (hdr_q == 3'd0) begin
					begin_pl = 1'b1;
				end else begin
					hdr_d = hdr_q - 3'd1;
				end
			end
			PH_PAYLOAD: begin
				mpos_d    = mpos_q + 2'd1;
				rem_d     = rem_dec;
				res.vld   = 1'b1;
				res.pbyte = data_s1 ^ key_byte;
				res.last  = (rem_dec == '0);
				if (rem_dec == '0) begin
					phase_d = PH_HDR0;
				end
			end
			PH_CLOSED: begin
				// stream ended; drop everything until reset
			end
			default: begin
				phase_d = PH_HDR0;
			end
		endcase

		if (len_done) begin
			if (mask_sel) begin
				phase_d = PH_KEY;
				hdr_d   = HDR_KEY;
				key_d   = '0;
			end else begin
				begin_pl = 1'b1;
			end
		end

		if (begin_pl) begin
			mpos_d = 2'd0;
			if (len_val == '0) begin
				phase_d  = PH_HDR0;
				res.vld  = 1'b1;
				res.kind = KIND_EMPTY;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		res.vld = res.vld && vld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			op_q    <= '0;
			mask_q  <= 1'b0;
			rem_q   <= '0;
			hdr_q   <= '0;
			key_q   <= '0;
			mpos_q  <= '0;
		end else if (consume) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			mask_q  <= mask_d;
			rem_q   <= rem_d;
			hdr_q   <= hdr_d;
			key_q   <= key_d;
			mpos_q  <= mpos_d;
		end
	end

	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |=> phase_q == PH_CLOSED)
		else $error("left closed state without reset");

	a_close_enters_closed: assert property (@(posedge clk) disable iff (!arst_n)
		consume && res.vld && res.kind == KIND_CLOSE |=> phase_q == PH_CLOSED)
		else $error("close item did not end the stream");

	a_payload_emits: assert property (@(posedge clk) disable iff (!arst_n)
		consume && phase_q == PH_PAYLOAD |-> res.vld && res.kind == KIND_PAYLOAD)
		else $error("payload byte produced no item");

	a_payload_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with zero length remaining");

endmodule

[sv/wsfd_out_stage.sv]
module wsfd_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  wsfd_pkg::res_t res,
	input  logic           consume,
	output logic           out_ready,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     kind,
	output logic [7:0]     payload_byte,
	output logic [3:0]     frame_opcode,
	output logic           last_of_frame
);
	import wsfd_pkg::*;

	logic       vld_s2;
	logic [1:0] kind_s2;
	logic [7:0] byte_s2;
	logic [3:0] op_s2;
	logic       last_s2;

	assign out_ready = !vld_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_ready) begin
			vld_s2 <= consume && res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && consume && res.vld) begin
			kind_s2 <= res.kind;
			byte_s2 <= res.pbyte;
			op_s2   <= res.opcode;
			last_s2 <= res.last;
		end
	end

	assign out_valid     = vld_s2;
	assign kind          = kind_s2;
	assign payload_byte  = byte_s2;
	assign frame_opcode  = op_s2;
	assign last_of_frame = last_s2;

endmodule

[bench/websocket_frame_deframer_core_test.sv]
`timescale 1ns / 100ps

module websocket_frame_deframer_core_test;

	import wsfd_pkg::*;

	localparam int LEN_W       = LENGTH_BITS_DEF;
	localparam int STREAM_BYTES = 1600;
	localparam int DRAIN_AT     = 800;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 500;
	localparam int CYCLE_LIMIT  = 600000;

	typedef enum int {
		FMT_SHORT,
		FMT_EXT16,
		FMT_EXT64
	} len_fmt_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] pbyte;
		logic [3:0] opcode;
		logic       last;
	} frame_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic       last_of_frame;

	websocket_frame_deframer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.payload_byte(payload_byte),
		.frame_opcode(frame_opcode),
		.last_of_frame(last_of_frame)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// byte stream to send and deframed items still due
	logic [7:0]    stream_q[$];
	frame_result_t deframed_q[$];

	int          errors = 0;
	int unsigned cycle_count = 0;
	int          sent = 0;
	int          gap_left = 0;
	bit          drain_hold = 1'b0;
	int          results_seen = 0;
	int          stall_left = 0;
	int          long_hold_left = 0;
	bit          long_hold_done = 1'b0;
	frame_result_t want;

	// parser state of the predictor
	phase_t           ph_state = PH_HDR0;
	logic [3:0]       cur_op = 4'h0;
	logic             mask_on = 1'b0;
	logic [LEN_W-1:0] len_left = '0;
	logic [2:0]       hdr_left = 3'd0;
	logic [31:0]      mask_word = 32'h0;
	logic [1:0]       mask_idx = 2'd0;

	task automatic report_mismatch(input string what);
		$display("mismatch @%0d: %s", cycle_count, what);
		errors++;
	endtask

	task automatic stream_add(input logic [7:0] b);
		stream_q.insert(stream_q.size(), b);
	endtask

	task automatic push_result(input kind_t k, input logic [7:0] p, input logic l);
		frame_result_t r;
		r.kind   = k;
		r.pbyte  = p;
		r.opcode = cur_op;
		r.last   = l;
		deframed_q.insert(deframed_q.size(), r);
	endtask

	task automatic start_payload();
		mask_idx = 2'd0;
		if (len_left == 0) begin
			ph_state = PH_HDR0;
			push_result(KIND_EMPTY, 8'h00, 1'b1);
		end else begin
			ph_state = PH_PAYLOAD;
		end
	endtask

	task automatic length_complete();
		if (mask_on) begin
			ph_state = PH_KEY;
			hdr_left = HDR_KEY;
			mask_word = 32'h0;
		end else begin
			start_payload();
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0] kb;
		case (ph_state)
			PH_HDR0: begin
				cur_op = b[3:0];
				ph_state = PH_HDR1;
			end
			PH_HDR1: begin
				mask_on = b[7];
				if (cur_op == OP_CLOSE) begin
					ph_state = PH_CLOSED;
					push_result(KIND_CLOSE, 8'h00, 1'b1);
				end else begin
					len_left = '0;
					if (b[6:0] == LEN_EXT16) begin
						hdr_left = HDR_EXT16;
						ph_state = PH_EXTLEN;
					end else if (b[6:0] == LEN_EXT64) begin
						hdr_left = HDR_EXT64;
						ph_state = PH_EXTLEN;
					end else begin
						len_left = LEN_W'(b[6:0]);
						length_complete();
					end
				end
			end
			PH_EXTLEN: begin
				len_left = (len_left << 8) | LEN_W'(b);
				if (hdr_left == 0)
					length_complete();
				else
					hdr_left = hdr_left - 3'd1;
			end
			PH_KEY: begin
				mask_word = {mask_word[23:0], b};
				if (hdr_left == 0)
					start_payload();
				else
					hdr_left = hdr_left - 3'd1;
			end
			PH_PAYLOAD: begin
				kb = mask_on ? mask_word[8 * (3 - int'(mask_idx)) +: 8] : 8'h00;
				mask_idx = mask_idx + 2'd1;
				len_left = len_left - 1'b1;
				if (len_left == 0) begin
					ph_state = PH_HDR0;
					push_result(KIND_PAYLOAD, b ^ kb, 1'b1);
				end else begin
					push_result(KIND_PAYLOAD, b ^ kb, 1'b0);
				end
			end
			PH_CLOSED: begin
			end
			default: ph_state = PH_HDR0;
		endcase
	endtask

	task automatic add_frame(input logic [3:0] op, input bit masked, input int len,
			input len_fmt_t fmt);
		longint ln;
		ln = len;
		stream_add({4'($urandom_range(0, 15)), op});
		case (fmt)
			FMT_SHORT: stream_add({masked, 7'(len)});
			FMT_EXT16: begin
				stream_add({masked, LEN_EXT16});
				stream_add(8'(ln >> 8));
				stream_add(8'(ln));
			end
			default: begin
				stream_add({masked, LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					stream_add(8'(ln >> (8 * i)));
			end
		endcase
		if (masked)
			repeat (4) stream_add(8'($urandom_range(0, 255)));
		repeat (len) stream_add(8'($urandom_range(0, 255)));
	endtask

	// mostly short idles, a few long ones; none inside quiet stretches
	function automatic int idle_len(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				deframe_byte(data_byte);
			if (!in_valid || !in_stall) begin
				if (drain_hold) begin
					in_valid <= 1'b0;
					if (deframed_q.size() == 0)
						drain_hold <= 1'b0;
				end else if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (stream_q.size() != 0) begin
					in_valid <= 1'b1;
					data_byte <= stream_q.pop_front();
					sent <= sent + 1;
					gap_left <= idle_len((sent / 200) % 3 == 1);
					if (sent == DRAIN_AT)
						drain_hold <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		int n;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (deframed_q.size() == 0) begin
					report_mismatch($sformatf("item with nothing due: kind %0d byte %02h",
						kind, payload_byte));
				end else begin
					want = deframed_q.pop_front();
					if (kind !== want.kind)
						report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
					if (payload_byte !== want.pbyte)
						report_mismatch($sformatf("payload_byte %02h, want %02h",
							payload_byte, want.pbyte));
					if (frame_opcode !== want.opcode)
						report_mismatch($sformatf("frame_opcode %0h, want %0h",
							frame_opcode, want.opcode));
					if (last_of_frame !== want.last)
						report_mismatch($sformatf("last_of_frame %0b, want %0b",
							last_of_frame, want.last));
				end
			end
			if (long_hold_left != 0) begin
				out_stall <= 1'b1;
				long_hold_left <= long_hold_left - 1;
			end else if (!long_hold_done && results_seen >= HOLD_AT) begin
				// long hold-off so the block backs up into its input
				out_stall <= 1'b1;
				long_hold_left <= HOLD_CYCLES;
				long_hold_done <= 1'b1;
			end else if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				n = idle_len((cycle_count / 1500) % 4 == 3);
				out_stall <= (n != 0);
				stall_left <= (n != 0) ? n - 1 : 0;
			end
		end
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [3:0] op;
		int r;
		int len;
		len_fmt_t fmt;

		add_frame(4'h1, 1'b0, 0, FMT_SHORT);
		add_frame(4'h2, 1'b1, 0, FMT_SHORT);
		add_frame(4'h0, 1'b0, 3, FMT_SHORT);
		add_frame(4'h9, 1'b1, 4, FMT_SHORT);
		add_frame(4'hA, 1'b0, 0, FMT_EXT16);
		add_frame(4'hF, 1'b1, 0, FMT_EXT64);
		add_frame(4'h3, 1'b1, 2, FMT_EXT64);

		while (stream_q.size() < STREAM_BYTES) begin
			do
				op = 4'($urandom_range(0, 15));
			while (op == OP_CLOSE);
			r = $urandom_range(0, 99);
			if (r < 50) begin
				fmt = FMT_SHORT;
				len = $urandom_range(0, 12);
			end else if (r < 65) begin
				fmt = FMT_SHORT;
				len = $urandom_range(0, 125);
			end else if (r < 80) begin
				fmt = FMT_EXT16;
				len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 40)
					: $urandom_range(126, 300);
			end else begin
				fmt = FMT_EXT64;
				len = $urandom_range(0, 40);
			end
			add_frame(op, 1'($urandom_range(0, 1)), len, fmt);
		end

		// close frame ends the stream; the trailing bytes must be dropped
		stream_add({4'($urandom_range(0, 15)), OP_CLOSE});
		repeat (7) stream_add(8'($urandom_range(0, 255)));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stream_q.size() != 0 || in_valid)
			@(negedge clk);
		while (deframed_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
